// ===== hw/rtl/efd_pkg.sv =====
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants for the escaped frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

    // Default payload buffer size in bytes
    localparam int BUF_BYTES_DEF = 64;

    // Depth of the queue between the front end and the parser
    localparam int Q_DEPTH = 2;

    // Widths of the fixed fields
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 16;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 8'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] START_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] END_RST    = 8'd3;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd27;

    // Parser phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RCV  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ESC  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd4;

    // Classified received byte, as passed from front end to parser
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              ready;
        logic              is_start;
        logic              is_end;
        logic              is_esc;
    } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/efd_front.sv =====
// ----------------------------------------------------------------------------
// efd_front
// Holds the framing byte registers, classifies each received byte and
// queues it for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [efd_pkg::BYTE_W-1:0]     cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [efd_pkg::BYTE_W-1:0]     rx_byte,
    input  wire logic                           sink_ready,
    // queue towards the parser
    output logic                                q_valid,
    output efd_pkg::item_t                      q_item,
    input  wire logic                           q_pop
);

    localparam int PTR_W = (efd_pkg::Q_DEPTH > 1) ? $clog2(efd_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(efd_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(efd_pkg::Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(efd_pkg::Q_DEPTH);

    logic [efd_pkg::BYTE_W-1:0] start_reg, end_reg, esc_reg;

    efd_pkg::item_t             q_mem_reg [efd_pkg::Q_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    efd_pkg::item_t             item_in;
    logic                       push;

    // Framing byte registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= efd_pkg::START_RST;
            end_reg   <= efd_pkg::END_RST;
            esc_reg   <= efd_pkg::ESCAPE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == efd_pkg::CFG_START)
                start_reg <= cfg_data;
            if (cfg_index == efd_pkg::CFG_END)
                end_reg <= cfg_data;
            if (cfg_index == efd_pkg::CFG_ESCAPE)
                esc_reg <= cfg_data;
        end
    end

    // Classify the incoming byte against the framing values
    always_comb
    begin
        item_in.data     = rx_byte;
        item_in.ready    = sink_ready;
        item_in.is_start = (rx_byte == start_reg);
        item_in.is_end   = (rx_byte == end_reg);
        item_in.is_esc   = (rx_byte == esc_reg);
    end

    // Queue handshake
    assign in_stall = (count_reg == CNT_FULL);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (q_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= item_in;
    end

    // Assertions
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue occupancy beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy did not follow a lone transfer in");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("parser popped an empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/efd_back.sv =====
// ----------------------------------------------------------------------------
// efd_back
// Frame parser: runs the phase machine on each queued byte, tracks buffer
// fill and counters, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_back
#(
    parameter int BUF_BYTES = efd_pkg::BUF_BYTES_DEF,
    localparam int IDX_W  = $clog2(BUF_BYTES),
    localparam int FILL_W = $clog2(BUF_BYTES + 1)
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // queue from the front end
    input  wire logic                           q_valid,
    input  wire efd_pkg::item_t                 q_item,
    output logic                                q_pop,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                store_valid,
    output logic                                store_buffer,
    output logic [IDX_W-1:0]                    store_index,
    output logic [efd_pkg::BYTE_W-1:0]          store_data,
    output logic                                frame_done,
    output logic                                frame_buffer,
    output logic [FILL_W-1:0]                   frame_length,
    output logic                                frame_dropped,
    output logic [efd_pkg::CNT_W-1:0]           received_total,
    output logic [efd_pkg::CNT_W-1:0]           dropped_total,
    output logic [efd_pkg::PHASE_W-1:0]         parse_state
);

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUF_BYTES);

    // Parser state
    logic [efd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                        active_reg, active_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [efd_pkg::CNT_W-1:0]   rx_cnt_reg, rx_cnt_next;
    logic [efd_pkg::CNT_W-1:0]   drop_cnt_reg, drop_cnt_next;
    logic                        out_valid_reg, out_valid_next;

    // Result payload
    logic                        sv_reg, sv_next;
    logic                        sb_reg, sb_next;
    logic [IDX_W-1:0]            si_reg, si_next;
    logic [efd_pkg::BYTE_W-1:0]  sd_reg, sd_next;
    logic                        fd_reg, fd_next;
    logic                        fb_reg, fb_next;
    logic [FILL_W-1:0]           fl_reg, fl_next;
    logic                        dr_reg, dr_next;

    logic                        do_store;
    logic                        do_drop;

    // Take a byte whenever the output register is free or being emptied
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    // Phase machine for one byte
    always_comb
    begin
        phase_next    = phase_reg;
        active_next   = active_reg;
        fill_next     = fill_reg;
        rx_cnt_next   = rx_cnt_reg;
        drop_cnt_next = drop_cnt_reg;
        sv_next = 1'b0;
        sb_next = 1'b0;
        si_next = '0;
        sd_next = '0;
        fd_next = 1'b0;
        fb_next = 1'b0;
        fl_next = '0;
        dr_next = 1'b0;
        do_store = 1'b0;
        do_drop  = 1'b0;

        unique case (phase_reg)
            efd_pkg::PH_RCV:
            begin
                // escape is tested before end
                if (q_item.is_esc)
                    phase_next = efd_pkg::PH_ESC;
                else if (q_item.is_end)
                begin
                    phase_next = efd_pkg::PH_DONE;
                    if (q_item.ready)
                    begin
                        fd_next     = 1'b1;
                        fb_next     = active_reg;
                        fl_next     = fill_reg;
                        active_next = ~active_reg;
                        fill_next   = '0;
                        rx_cnt_next = rx_cnt_reg + 1'b1;
                    end
                    else
                        do_drop = 1'b1;
                end
                else
                    do_store = 1'b1;
            end
            efd_pkg::PH_ESC:
            begin
                if (q_item.is_esc || q_item.is_start || q_item.is_end)
                begin
                    phase_next = efd_pkg::PH_RCV;
                    do_store   = 1'b1;
                end
                else
                begin
                    do_drop    = 1'b1;
                    phase_next = efd_pkg::PH_HUNT;
                end
            end
            default:
            begin
                // idle, hunting or done: wait for the start byte
                if (q_item.is_start)
                    phase_next = efd_pkg::PH_RCV;
            end
        endcase

        // Payload write, or overflow
        if (do_store)
        begin
            if (fill_reg < FILL_MAX)
            begin
                sv_next   = 1'b1;
                sb_next   = active_reg;
                si_next   = fill_reg[IDX_W-1:0];
                sd_next   = q_item.data;
                fill_next = fill_reg + 1'b1;
            end
            else
            begin
                do_drop    = 1'b1;
                phase_next = efd_pkg::PH_HUNT;
            end
        end

        // Frame discard
        if (do_drop)
        begin
            fill_next     = '0;
            drop_cnt_next = drop_cnt_reg + 1'b1;
            dr_next       = 1'b1;
        end
    end

    // Output register valid
    always_comb
    begin
        if (q_pop)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= efd_pkg::PH_IDLE;
            active_reg    <= 1'b0;
            fill_reg      <= '0;
            rx_cnt_reg    <= '0;
            drop_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg    <= phase_next;
                active_reg   <= active_next;
                fill_reg     <= fill_next;
                rx_cnt_reg   <= rx_cnt_next;
                drop_cnt_reg <= drop_cnt_next;
            end
        end
    end

    // Result payload, loaded on each transfer from the queue
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sv_reg <= sv_next;
            sb_reg <= sb_next;
            si_reg <= si_next;
            sd_reg <= sd_next;
            fd_reg <= fd_next;
            fb_reg <= fb_next;
            fl_reg <= fl_next;
            dr_reg <= dr_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign store_valid    = sv_reg;
    assign store_buffer   = sb_reg;
    assign store_index    = si_reg;
    assign store_data     = sd_reg;
    assign frame_done     = fd_reg;
    assign frame_buffer   = fb_reg;
    assign frame_length   = fl_reg;
    assign frame_dropped  = dr_reg;
    assign received_total = rx_cnt_reg;
    assign dropped_total  = drop_cnt_reg;
    assign parse_state    = phase_reg;

    // Assertions
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill level beyond buffer size");

    a_stays_active: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != efd_pkg::PH_IDLE) |=> (phase_reg != efd_pkg::PH_IDLE))
        else $error("parser returned to idle after leaving it");

    a_rx_count: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !fd_next) |=> $stable(rx_cnt_reg))
        else $error("received count moved without a delivered frame");

    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fd_reg) |-> (phase_reg == efd_pkg::PH_DONE && !dr_reg))
        else $error("delivered frame with inconsistent phase or drop");

endmodule

`default_nettype wire

// ===== hw/rtl/escaped_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_deframer
// STX/ETX deframer with escape-byte stuffing and ping-pong buffer reporting.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while in_stall is low, and one result
// leaves for each byte, so the sustained rate is one item per cycle while
// out_stall is low; a result passes through the two-entry classify queue and
// then the output register after its byte is transferred in. The rate is set
// by the parser's update of phase, fill level and counters for each byte.
// Framing values must only be rewritten while no bytes are in flight. Output
// stall backs up into the queue and then onto in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_deframer
#(
    parameter int BUF_BYTES = efd_pkg::BUF_BYTES_DEF,
    localparam int IDX_W  = $clog2(BUF_BYTES),
    localparam int FILL_W = $clog2(BUF_BYTES + 1)
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [efd_pkg::BYTE_W-1:0]     cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [efd_pkg::BYTE_W-1:0]     rx_byte,
    input  wire logic                           sink_ready,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                store_valid,
    output logic                                store_buffer,
    output logic [IDX_W-1:0]                    store_index,
    output logic [efd_pkg::BYTE_W-1:0]          store_data,
    output logic                                frame_done,
    output logic                                frame_buffer,
    output logic [FILL_W-1:0]                   frame_length,
    output logic                                frame_dropped,
    output logic [efd_pkg::CNT_W-1:0]           received_total,
    output logic [efd_pkg::CNT_W-1:0]           dropped_total,
    output logic [efd_pkg::PHASE_W-1:0]         parse_state
);

    logic           q_valid;
    logic           q_pop;
    efd_pkg::item_t q_item;

    // Classify and queue
    efd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .sink_ready (sink_ready),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Parse and report
    efd_back
    #(
        .BUF_BYTES (BUF_BYTES)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .store_valid    (store_valid),
        .store_buffer   (store_buffer),
        .store_index    (store_index),
        .store_data     (store_data),
        .frame_done     (frame_done),
        .frame_buffer   (frame_buffer),
        .frame_length   (frame_length),
        .frame_dropped  (frame_dropped),
        .received_total (received_total),
        .dropped_total  (dropped_total),
        .parse_state    (parse_state)
    );

endmodule

`default_nettype wire
